FILE: design/dvre_pkg.sv
// ----------------------------------------------------------------------------
// dvre_pkg
// Shared types and constants of the distance-vector route engine: item
// structs, mode codes, configuration register indexes and defaults.
// ----------------------------------------------------------------------------
package dvre_pkg;

  localparam int NODES_DEF     = 16;
  localparam int COST_BITS_DEF = 16;
  localparam int MAX_RESULTS   = 16;

  localparam int MODE_W = 2;
  localparam int NODE_W = 4;
  localparam int COST_W = 16;

  localparam logic [MODE_W-1:0] MODE_DATA   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_UPDATE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_LOAD   = 2'd2;
  localparam logic [MODE_W-1:0] MODE_DUMP   = 2'd3;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_OWN_NODE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_INF_COST = 1'b1;

  localparam logic [NODE_W-1:0] OWN_NODE_RESET = 4'd0;
  localparam logic [COST_W-1:0] INF_RESET      = 16'hFFFF;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [NODE_W-1:0] neighbour;
    logic [NODE_W-1:0] dest_node;
    logic [COST_W-1:0] cost;
  } in_item_t;

  typedef struct packed {
    logic              deliver_local;
    logic              route_valid;
    logic [NODE_W-1:0] next_hop;
    logic [NODE_W-1:0] node;
    logic [COST_W-1:0] path_cost;
    logic              changed;
    logic              last;
  } out_item_t;

endpackage

FILE: design/distance_vector_route_engine.sv
// ----------------------------------------------------------------------------
// distance_vector_route_engine
// Distance-vector route table with packet lookup, route relaxation, link
// load and vector dump, held in two simple dual-port synchronous memories.
// ----------------------------------------------------------------------------
//  channel  ports                              transfer
//  input    start, busy, in_item               start & !busy
//  result   out_valid, out_item                out_valid (one cycle)
//  config   cfg_valid, cfg_ready, cfg_index,   cfg_valid & cfg_ready
//           cfg_data
//
//  Lookup, update and load: a memory read, then modify and write back.
//  Dump: min(NODES,16) entries, one entry per cycle from the route read port.
//  Reset clears control state and the per-entry written marks;
//  unwritten entries read as the reset infinite cost (INF_RESET), no hop, not valid.
//  busy holds off start; results cannot be stalled; cfg_ready is always high.
// ----------------------------------------------------------------------------
module distance_vector_route_engine #(
  parameter int NODES     = dvre_pkg::NODES_DEF,
  parameter int COST_BITS = dvre_pkg::COST_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  dvre_pkg::in_item_t              in_item,
  output logic                            out_valid,
  output dvre_pkg::out_item_t             out_item,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [dvre_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [dvre_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int IDXW = $clog2(NODES);
  localparam int RT_W = COST_BITS + dvre_pkg::NODE_W + 1;
  localparam int DUMP_N = (NODES < dvre_pkg::MAX_RESULTS) ? NODES : dvre_pkg::MAX_RESULTS;
  localparam logic [dvre_pkg::NODE_W-1:0] DUMP_LAST = dvre_pkg::NODE_W'(DUMP_N - 1);
  localparam logic [COST_BITS-1:0] TBL_RESET = COST_BITS'(dvre_pkg::INF_RESET);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EXEC = 1'b1;

  function automatic logic in_range(input logic [dvre_pkg::NODE_W-1:0] n);
    return (32'(n) < NODES);
  endfunction

  function automatic logic [IDXW-1:0] to_addr(input logic [dvre_pkg::NODE_W-1:0] n);
    return in_range(n) ? IDXW'(n) : '0;
  endfunction

  logic [COST_BITS-1:0] link_mem  [NODES];
  logic [RT_W-1:0]      route_mem [NODES];

  logic                            state_r, state_nxt;
  logic [dvre_pkg::NODE_W-1:0]     cnt_r, cnt_nxt;
  dvre_pkg::in_item_t              item_r, item_nxt;
  logic [dvre_pkg::NODE_W-1:0]     own_r;
  logic [dvre_pkg::COST_W-1:0]     inf_r;
  logic [NODES-1:0]                lk_wr_r, rt_wr_r;
  logic                            out_valid_r, out_valid_nxt;
  dvre_pkg::out_item_t             out_item_r, out_item_nxt;
  logic [COST_BITS-1:0]            lk_rd_r;
  logic [RT_W-1:0]                 rt_rd_r;
  logic                            lk_rd_wr_r, rt_rd_wr_r;

  logic                            accept;
  logic [IDXW-1:0]                 lk_raddr, rt_raddr, rt_waddr, lk_waddr;
  logic                            lk_we, rt_we;
  logic [RT_W-1:0]                 rt_wdata;
  logic [COST_BITS-1:0]            lk_eff, best_eff, inf_c, cost_c, sum_sat;
  logic [dvre_pkg::NODE_W-1:0]     hop_eff;
  logic                            vld_eff, nb_ok, dst_ok, upd, dump_last;
  logic [COST_BITS:0]              sum_raw;

  assign busy      = state_r;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;
  assign accept    = start && !busy;

  // read addresses
  always_comb begin
    lk_raddr = to_addr(in_item.neighbour);
    if (state_r == ST_EXEC) begin
      rt_raddr = (cnt_r == DUMP_LAST) ? '0 : IDXW'(cnt_r + 4'd1);
    end else begin
      case (in_item.mode)
        dvre_pkg::MODE_LOAD: rt_raddr = to_addr(in_item.neighbour);
        dvre_pkg::MODE_DUMP: rt_raddr = '0;
        default:             rt_raddr = to_addr(in_item.dest_node);
      endcase
    end
  end

  always_ff @(posedge clk) begin
    lk_rd_r    <= link_mem[lk_raddr];
    lk_rd_wr_r <= lk_wr_r[lk_raddr];
    rt_rd_r    <= route_mem[rt_raddr];
    rt_rd_wr_r <= rt_wr_r[rt_raddr];
    if (lk_we) begin
      link_mem[lk_waddr] <= cost_c;
    end
    if (rt_we) begin
      route_mem[rt_waddr] <= rt_wdata;
    end
  end

  // modify
  always_comb begin
    inf_c    = COST_BITS'(inf_r);
    cost_c   = COST_BITS'(item_r.cost);
    lk_eff   = lk_rd_wr_r ? lk_rd_r : TBL_RESET;
    best_eff = rt_rd_wr_r ? rt_rd_r[COST_BITS-1:0] : TBL_RESET;
    hop_eff  = rt_rd_wr_r ? rt_rd_r[COST_BITS+dvre_pkg::NODE_W-1:COST_BITS] : '0;
    vld_eff  = rt_rd_wr_r && rt_rd_r[RT_W-1];
    nb_ok    = in_range(item_r.neighbour);
    dst_ok   = in_range(item_r.dest_node);
    sum_raw  = {1'b0, lk_eff} + (COST_BITS+1)'(cost_c);
    sum_sat  = (sum_raw > {1'b0, inf_c}) ? inf_c : sum_raw[COST_BITS-1:0];
    upd      = sum_sat < best_eff;
    dump_last = (cnt_r == DUMP_LAST);

    lk_we    = 1'b0;
    rt_we    = 1'b0;
    lk_waddr = to_addr(item_r.neighbour);
    rt_waddr = to_addr(item_r.dest_node);
    rt_wdata = {1'b1, item_r.neighbour, sum_sat};

    out_item_nxt = '0;
    out_item_nxt.last = 1'b1;

    case (item_r.mode)
      dvre_pkg::MODE_DATA: begin
        out_item_nxt.node = item_r.dest_node;
        if (item_r.dest_node == own_r) begin
          out_item_nxt.deliver_local = 1'b1;
          out_item_nxt.path_cost = dst_ok ? dvre_pkg::COST_W'(best_eff) : inf_r;
        end else if (dst_ok) begin
          out_item_nxt.route_valid = vld_eff;
          out_item_nxt.next_hop    = hop_eff;
          out_item_nxt.path_cost   = dvre_pkg::COST_W'(best_eff);
        end else begin
          out_item_nxt.path_cost = inf_r;
        end
      end
      dvre_pkg::MODE_UPDATE: begin
        out_item_nxt.node = item_r.dest_node;
        if (nb_ok && dst_ok) begin
          rt_we = (state_r == ST_EXEC) && upd;
          out_item_nxt.changed     = upd;
          out_item_nxt.route_valid = upd || vld_eff;
          out_item_nxt.next_hop    = upd ? item_r.neighbour : hop_eff;
          out_item_nxt.path_cost   = dvre_pkg::COST_W'(upd ? sum_sat : best_eff);
        end else begin
          out_item_nxt.path_cost = inf_r;
        end
      end
      dvre_pkg::MODE_LOAD: begin
        out_item_nxt.node = item_r.neighbour;
        rt_waddr = to_addr(item_r.neighbour);
        rt_wdata = {(cost_c < inf_c), item_r.neighbour, cost_c};
        if (nb_ok) begin
          lk_we = (state_r == ST_EXEC);
          rt_we = (state_r == ST_EXEC);
          out_item_nxt.route_valid = cost_c < inf_c;
          out_item_nxt.next_hop    = item_r.neighbour;
          out_item_nxt.path_cost   = dvre_pkg::COST_W'(cost_c);
        end else begin
          out_item_nxt.path_cost = inf_r;
        end
      end
      default: begin
        out_item_nxt.node        = cnt_r;
        out_item_nxt.route_valid = vld_eff;
        out_item_nxt.next_hop    = hop_eff;
        out_item_nxt.path_cost   = dvre_pkg::COST_W'(best_eff);
        out_item_nxt.last        = dump_last;
      end
    endcase
  end

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    item_nxt      = item_r;
    out_valid_nxt = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_EXEC;
          cnt_nxt   = '0;
          item_nxt  = in_item;
        end
      end
      default: begin
        out_valid_nxt = 1'b1;
        if (item_r.mode != dvre_pkg::MODE_DUMP || dump_last) begin
          state_nxt = ST_IDLE;
        end else begin
          cnt_nxt = cnt_r + 4'd1;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      own_r       <= dvre_pkg::OWN_NODE_RESET;
      inf_r       <= dvre_pkg::INF_RESET;
      lk_wr_r     <= '0;
      rt_wr_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
      if (lk_we) begin
        lk_wr_r[lk_waddr] <= 1'b1;
      end
      if (rt_we) begin
        rt_wr_r[rt_waddr] <= 1'b1;
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          dvre_pkg::CFG_OWN_NODE: own_r <= cfg_data[dvre_pkg::NODE_W-1:0];
          dvre_pkg::CFG_INF_COST: inf_r <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    item_r     <= item_nxt;
    out_item_r <= out_item_nxt;
  end

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> busy)
    else $error("accepted item did not raise busy");

  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.last) |-> !busy)
    else $error("final result while engine still busy");

  a_out_from_exec: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(state_r) == ST_EXEC)
    else $error("result transfer without an executing item");

  a_write_exec: assert property (@(posedge clk) disable iff (!rst_n)
    (lk_we || rt_we) |-> (state_r == ST_EXEC && item_r.mode != dvre_pkg::MODE_DUMP))
    else $error("table write outside an update or load");

  a_dump_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EXEC && item_r.mode == dvre_pkg::MODE_DUMP) |-> cnt_r <= DUMP_LAST)
    else $error("dump index past final entry");

endmodule

FILE: sim/distance_vector_route_engine_tb.sv
// ----------------------------------------------------------------------------
// distance_vector_route_engine_tb
// Self-checking bench for the distance-vector route engine. A behavioural
// route table predicts every result of packet lookups, route updates, link
// loads and vector dumps. The expectations are queued in order and compared
// field by field with each result strobe. Directed cases cover reset state,
// saturation, ties, local delivery and the register extremes. Random traffic
// then runs under several own-node and infinite-cost settings, with random
// gaps on the input side in all runs but the quiet one.
// ----------------------------------------------------------------------------
module distance_vector_route_engine_tb;

  localparam int WATCHDOG_LIMIT = 1000;
  localparam int DUMP_LEN = (dvre_pkg::NODES_DEF < dvre_pkg::MAX_RESULTS) ?
                            dvre_pkg::NODES_DEF : dvre_pkg::MAX_RESULTS;

  logic                            clk;
  logic                            rst_n;
  logic                            start;
  logic                            busy;
  dvre_pkg::in_item_t              in_item;
  logic                            out_valid;
  dvre_pkg::out_item_t             out_item;
  logic                            cfg_valid;
  logic                            cfg_ready;
  logic [dvre_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [dvre_pkg::CFG_DATA_W-1:0] cfg_data;

  logic [dvre_pkg::COST_W-1:0] link_cost [dvre_pkg::NODES_DEF];
  logic [dvre_pkg::COST_W-1:0] best_cost [dvre_pkg::NODES_DEF];
  logic [dvre_pkg::NODE_W-1:0] hop       [dvre_pkg::NODES_DEF];
  logic                        hop_ok    [dvre_pkg::NODES_DEF];
  logic [dvre_pkg::NODE_W-1:0] own_node;
  logic [dvre_pkg::COST_W-1:0] inf_cost;

  dvre_pkg::out_item_t expected_routes[$];
  int                  mismatches;
  int                  quiet_cycles;
  bit                  sender_quiet;

  distance_vector_route_engine i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #6 clk = ~clk;

  function automatic dvre_pkg::out_item_t entry_report(logic [dvre_pkg::NODE_W-1:0] n,
                                                       logic ch, logic lst);
    dvre_pkg::out_item_t r;
    r.deliver_local = 1'b0;
    r.route_valid   = hop_ok[n];
    r.next_hop      = hop[n];
    r.node          = n;
    r.path_cost     = best_cost[n];
    r.changed       = ch;
    r.last          = lst;
    return r;
  endfunction

  task automatic clear_routes();
    own_node = dvre_pkg::OWN_NODE_RESET;
    inf_cost = dvre_pkg::INF_RESET;
    for (int i = 0; i < dvre_pkg::NODES_DEF; i++) begin
      link_cost[i] = dvre_pkg::INF_RESET;
      best_cost[i] = dvre_pkg::INF_RESET;
      hop[i]       = '0;
      hop_ok[i]    = 1'b0;
    end
  endtask

  task automatic relax_route(dvre_pkg::in_item_t it);
    dvre_pkg::out_item_t         r;
    logic [dvre_pkg::COST_W:0]   sum;
    logic                        ch;
    case (it.mode)
      dvre_pkg::MODE_DATA: begin
        if (it.dest_node == own_node) begin
          r = '0;
          r.deliver_local = 1'b1;
          r.node          = it.dest_node;
          r.path_cost     = best_cost[it.dest_node];
          r.last          = 1'b1;
        end else begin
          r = entry_report(it.dest_node, 1'b0, 1'b1);
        end
        expected_routes.push_back(r);
      end
      dvre_pkg::MODE_UPDATE: begin
        ch  = 1'b0;
        sum = {1'b0, link_cost[it.neighbour]} + {1'b0, it.cost};
        if (sum > {1'b0, inf_cost}) sum = {1'b0, inf_cost};
        if (sum[dvre_pkg::COST_W-1:0] < best_cost[it.dest_node]) begin
          best_cost[it.dest_node] = sum[dvre_pkg::COST_W-1:0];
          hop[it.dest_node]       = it.neighbour;
          hop_ok[it.dest_node]    = 1'b1;
          ch = 1'b1;
        end
        expected_routes.push_back(entry_report(it.dest_node, ch, 1'b1));
      end
      dvre_pkg::MODE_LOAD: begin
        link_cost[it.neighbour] = it.cost;
        best_cost[it.neighbour] = it.cost;
        hop[it.neighbour]       = it.neighbour;
        hop_ok[it.neighbour]    = it.cost < inf_cost;
        expected_routes.push_back(entry_report(it.neighbour, 1'b0, 1'b1));
      end
      default: begin
        for (int i = 0; i < DUMP_LEN; i++)
          expected_routes.push_back(entry_report(dvre_pkg::NODE_W'(i), 1'b0,
                                                 i == DUMP_LEN - 1));
      end
    endcase
  endtask

  function automatic dvre_pkg::in_item_t mk_item(logic [dvre_pkg::MODE_W-1:0] m,
                                                 int nb, int dst, int c);
    dvre_pkg::in_item_t it;
    it.mode      = m;
    it.neighbour = dvre_pkg::NODE_W'(nb);
    it.dest_node = dvre_pkg::NODE_W'(dst);
    it.cost      = dvre_pkg::COST_W'(c);
    return it;
  endfunction

  function automatic logic [dvre_pkg::COST_W-1:0] pick_cost();
    int r;
    r = $urandom_range(99);
    if (r < 30) return dvre_pkg::COST_W'($urandom_range(63));
    if (r < 45) begin
      case ($urandom_range(4))
        0: return '0;
        1: return inf_cost;
        2: return inf_cost - 1'b1;
        3: return inf_cost + 1'b1;
        default: return '1;
      endcase
    end
    return dvre_pkg::COST_W'($urandom);
  endfunction

  // call at a falling edge; returns at a falling edge with start still high
  task automatic send_item(dvre_pkg::in_item_t it);
    if (!sender_quiet) begin
      while ($urandom_range(99) < 20) begin
        start = 1'b0;
        @(negedge clk);
      end
    end
    start   = 1'b1;
    in_item = it;
    do @(posedge clk); while (busy);
    relax_route(it);
    @(negedge clk);
  endtask

  task automatic write_reg(logic [dvre_pkg::CFG_IDX_W-1:0] idx,
                           logic [dvre_pkg::CFG_DATA_W-1:0] val);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == dvre_pkg::CFG_OWN_NODE) own_node = val[dvre_pkg::NODE_W-1:0];
    else inf_cost = val[dvre_pkg::COST_W-1:0];
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic drain();
    start = 1'b0;
    while (expected_routes.size() != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic test_reset_state();
    send_item(mk_item(dvre_pkg::MODE_DATA, 0, 0, 0));
    send_item(mk_item(dvre_pkg::MODE_DATA, 4, 5, 16'hFFFF));
    send_item(mk_item(dvre_pkg::MODE_DUMP, 15, 15, 16'hFFFF));
  endtask

  task automatic test_link_load();
    send_item(mk_item(dvre_pkg::MODE_LOAD, 3, 0, 10));
    send_item(mk_item(dvre_pkg::MODE_LOAD, 15, 9, 0));
    send_item(mk_item(dvre_pkg::MODE_LOAD, 0, 0, 16'hFFFF));
    send_item(mk_item(dvre_pkg::MODE_LOAD, 7, 1, 16'hFFFE));
  endtask

  task automatic test_route_update();
    send_item(mk_item(dvre_pkg::MODE_UPDATE, 3, 9, 5));
    send_item(mk_item(dvre_pkg::MODE_UPDATE, 3, 9, 5));
    send_item(mk_item(dvre_pkg::MODE_UPDATE, 15, 9, 0));
    send_item(mk_item(dvre_pkg::MODE_UPDATE, 0, 12, 16'hFFFF));
    send_item(mk_item(dvre_pkg::MODE_UPDATE, 7, 12, 1));
    send_item(mk_item(dvre_pkg::MODE_UPDATE, 7, 13, 0));
    send_item(mk_item(dvre_pkg::MODE_UPDATE, 3, 3, 0));
  endtask

  task automatic test_packet_forward();
    send_item(mk_item(dvre_pkg::MODE_DATA, 1, 9, 77));
    send_item(mk_item(dvre_pkg::MODE_DATA, 2, 13, 0));
    send_item(mk_item(dvre_pkg::MODE_DATA, 15, 0, 16'hFFFF));
  endtask

  task automatic test_vector_dump();
    send_item(mk_item(dvre_pkg::MODE_DUMP, 0, 0, 0));
  endtask

  task automatic test_config_extremes();
    drain();
    write_reg(dvre_pkg::CFG_OWN_NODE, 16'd15);
    write_reg(dvre_pkg::CFG_INF_COST, 16'd0);
    send_item(mk_item(dvre_pkg::MODE_DATA, 0, 15, 0));
    send_item(mk_item(dvre_pkg::MODE_LOAD, 4, 0, 0));
    send_item(mk_item(dvre_pkg::MODE_UPDATE, 15, 2, 16'h1234));
    send_item(mk_item(dvre_pkg::MODE_DUMP, 5, 10, 16'h8000));
  endtask

  task automatic test_random_traffic(int own, int inf, int count, bit quiet);
    int                  r;
    int                  dst;
    dvre_pkg::in_item_t  it;
    drain();
    write_reg(dvre_pkg::CFG_OWN_NODE, dvre_pkg::CFG_DATA_W'(own));
    write_reg(dvre_pkg::CFG_INF_COST, dvre_pkg::CFG_DATA_W'(inf));
    sender_quiet = quiet;
    for (int k = 0; k < count; k++) begin
      r   = $urandom_range(99);
      dst = ($urandom_range(99) < 30) ? int'(own_node)
                                      : $urandom_range(dvre_pkg::NODES_DEF - 1);
      it  = mk_item(dvre_pkg::MODE_DATA, $urandom_range(dvre_pkg::NODES_DEF - 1), dst,
                    $urandom);
      if (r < 20) begin
        it.mode = dvre_pkg::MODE_LOAD;
        it.cost = pick_cost();
      end else if (r < 60) begin
        it.mode      = dvre_pkg::MODE_UPDATE;
        it.dest_node = dvre_pkg::NODE_W'($urandom_range(dvre_pkg::NODES_DEF - 1));
        it.cost      = pick_cost();
      end else if (r >= 92) begin
        it.mode = dvre_pkg::MODE_DUMP;
      end
      send_item(it);
    end
    sender_quiet = 1'b0;
  endtask

  always @(posedge clk) begin
    dvre_pkg::out_item_t want;
    if (rst_n && out_valid) begin
      if (expected_routes.size() == 0) begin
        if (mismatches < 10) $display("unexpected result: %p", out_item);
        mismatches++;
      end else begin
        want = expected_routes.pop_front();
        if (out_item.deliver_local !== want.deliver_local ||
            out_item.route_valid   !== want.route_valid   ||
            out_item.next_hop      !== want.next_hop      ||
            out_item.node          !== want.node          ||
            out_item.path_cost     !== want.path_cost     ||
            out_item.changed       !== want.changed       ||
            out_item.last          !== want.last) begin
          if (mismatches < 10)
            $display("mismatch: expected %p, got %p", want, out_item);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((start && !busy) || out_valid || (cfg_valid && cfg_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  initial begin
    clk          = 1'b0;
    rst_n        = 1'b0;
    start        = 1'b0;
    in_item      = '0;
    cfg_valid    = 1'b0;
    cfg_index    = '0;
    cfg_data     = '0;
    mismatches   = 0;
    quiet_cycles = 0;
    sender_quiet = 1'b0;
    clear_routes();
    repeat (6) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    test_reset_state();
    test_link_load();
    test_route_update();
    test_packet_forward();
    test_vector_dump();
    test_config_extremes();
    test_random_traffic(0, 65535, 64, 1'b0);
    test_random_traffic(15, 0, 64, 1'b0);
    test_random_traffic(7, 100, 64, 1'b1);
    test_random_traffic($urandom_range(15), $urandom_range(65535), 64, 1'b0);
    test_random_traffic(3, 65535, 64, 1'b0);

    drain();
    repeat (20) @(posedge clk);
    if (mismatches == 0 && expected_routes.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
